### src/pibb_pkg.sv
package pibb_pkg;

    // widths of the item fields
    localparam int unsigned CNT_W   = 13;
    localparam int unsigned HITS_W  = 24;
    localparam int unsigned SUM_W   = 56;
    localparam int unsigned VAL_W   = 48;
    localparam int unsigned COORD_W = 32;

    localparam logic [HITS_W-1:0] HITS_MAX = {HITS_W{1'b1}};
    localparam logic [SUM_W-1:0]  SUM_MAX  = {SUM_W{1'b1}};

    // request codes
    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_BIN   = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;
    localparam logic [1:0] REQ_CLEAR = 2'd3;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [1:0]                req_type;
        logic [15:0]               lyr_num;
        logic [15:0]               lyr_dtype;
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic [VAL_W-1:0]          point_value;
        logic [7:0]                read_index;
    } t_req;

    typedef struct packed {
        logic              matched;
        logic [7:0]        box_index;
        logic [HITS_W-1:0] hit_count;
        logic [SUM_W-1:0]  value_sum;
        logic [1:0]        status;
    } t_rsp;

    // beat that travels down the row of cells
    typedef struct packed {
        logic             valid;
        logic             done;
        logic [CNT_W-1:0] count;
        t_req             req;
        t_rsp             rsp;
    } t_tok;

endpackage

### src/point_in_box_binning.sv
// a beat passes the entering register and then the register of every cell on its way
// to the result strobe, for every request type, since each beat passes every cell once
// no new request is taken until the last result is out; busy stays high meanwhile
// the result strobe lasts one cycle and the receiver cannot stall it
// reset (synchronous, active low) empties the table and drops any beat in flight
module point_in_box_binning import pibb_pkg::*; #(
    parameter int unsigned MAX_BOXES = 256
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_start,
    input  t_req i_req,
    output logic o_busy,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam logic [CNT_W-1:0] DEPTH = CNT_W'(MAX_BOXES);

    logic             r_busy;
    logic [CNT_W-1:0] r_loaded;
    t_tok             r_tok;
    t_tok             n_tok;
    logic             n_acc;
    t_tok             w_chain [MAX_BOXES+1];

    assign n_acc = i_start && !r_busy;

    // results settled before the row: full table, out of range read, clear
    always_comb begin
        n_tok       = '0;
        n_tok.valid = 1'b1;
        n_tok.count = r_loaded;
        n_tok.req   = i_req;
        unique case (i_req.req_type)
            REQ_LOAD: begin
                if (r_loaded >= DEPTH) begin
                    n_tok.done       = 1'b1;
                    n_tok.rsp.status = ST_FULL;
                end else begin
                    n_tok.rsp.box_index = r_loaded[7:0];
                end
            end
            REQ_BIN: begin
            end
            REQ_READ: begin
                n_tok.rsp.box_index = i_req.read_index;
                if ({{(CNT_W-8){1'b0}}, i_req.read_index} >= r_loaded) begin
                    n_tok.done       = 1'b1;
                    n_tok.rsp.status = ST_RANGE;
                end
            end
            REQ_CLEAR: begin
                n_tok.done = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // control: fill count, busy flag and the entering beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_loaded    <= '0;
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_acc;
            if (n_acc) begin
                r_busy <= 1'b1;
                if (i_req.req_type == REQ_CLEAR) begin
                    r_loaded <= '0;
                end else if (i_req.req_type == REQ_LOAD && r_loaded < DEPTH) begin
                    r_loaded <= r_loaded + CNT_W'(1);
                end
            end else if (w_chain[MAX_BOXES].valid) begin
                r_busy <= 1'b0;
            end
        end
        if (n_acc) begin
            r_tok.done  <= n_tok.done;
            r_tok.count <= n_tok.count;
            r_tok.req   <= n_tok.req;
            r_tok.rsp   <= n_tok.rsp;
        end
    end

    assign w_chain[0] = r_tok;

    // row of cells, one box each
    for (genvar g = 0; g < MAX_BOXES; g++) begin : g_cell
        pibb_cell #(.IDX(g)) u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_tok  (w_chain[g]),
            .o_tok  (w_chain[g+1])
        );
    end

    assign o_busy  = r_busy;
    assign o_valid = w_chain[MAX_BOXES].valid;
    assign o_rsp   = w_chain[MAX_BOXES].rsp;

endmodule

### src/pibb_cell.sv
module pibb_cell import pibb_pkg::*; #(
    parameter int unsigned IDX = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_tok i_tok,
    output t_tok o_tok
);

    localparam logic [CNT_W-1:0] K = CNT_W'(IDX);

    logic signed [COORD_W-1:0] r_min_x, r_min_y, r_max_x, r_max_y;
    logic [31:0]               r_tag;
    logic [HITS_W-1:0]         r_hits;
    logic [SUM_W-1:0]          r_sum;
    t_tok                      r_tok;

    logic              n_hit;
    logic              n_load;
    logic              n_read;
    logic [HITS_W-1:0] n_hits;
    logic [SUM_W:0]    n_wide;
    logic [SUM_W-1:0]  n_sum;
    t_tok              n_tok;

    // decode what this beat asks of this cell
    always_comb begin
        n_load = i_tok.valid && !i_tok.done && i_tok.req.req_type == REQ_LOAD
                 && i_tok.count == K;
        n_read = i_tok.valid && !i_tok.done && i_tok.req.req_type == REQ_READ
                 && {{(CNT_W-8){1'b0}}, i_tok.req.read_index} == K;
        n_hit  = i_tok.valid && !i_tok.done && i_tok.req.req_type == REQ_BIN
                 && K < i_tok.count
                 && r_tag == {i_tok.req.lyr_num, i_tok.req.lyr_dtype}
                 && i_tok.req.min_x >= r_min_x && i_tok.req.min_x <= r_max_x
                 && i_tok.req.min_y >= r_min_y && i_tok.req.min_y <= r_max_y;
        n_hits = (r_hits == HITS_MAX) ? r_hits : r_hits + HITS_W'(1);
        n_wide = {1'b0, r_sum} + {{(SUM_W-VAL_W+1){1'b0}}, i_tok.req.point_value};
        n_sum  = n_wide[SUM_W] ? SUM_MAX : n_wide[SUM_W-1:0];
    end

    // result fields picked up on the way
    always_comb begin
        n_tok = i_tok;
        if (n_hit) begin
            n_tok.done          = 1'b1;
            n_tok.rsp.matched   = 1'b1;
            n_tok.rsp.box_index = K[7:0];
            n_tok.rsp.hit_count = n_hits;
            n_tok.rsp.value_sum = n_sum;
            n_tok.rsp.status    = ST_OK;
        end else if (n_read) begin
            n_tok.done          = 1'b1;
            n_tok.rsp.matched   = 1'b1;
            n_tok.rsp.hit_count = r_hits;
            n_tok.rsp.value_sum = r_sum;
        end else if (n_load) begin
            n_tok.done = 1'b1;
        end
    end

    // box storage of this cell
    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_min_x <= i_tok.req.min_x;
            r_min_y <= i_tok.req.min_y;
            r_max_x <= i_tok.req.max_x;
            r_max_y <= i_tok.req.max_y;
            r_tag   <= {i_tok.req.lyr_num, i_tok.req.lyr_dtype};
            r_hits  <= '0;
            r_sum   <= '0;
        end else if (n_hit) begin
            r_hits <= n_hits;
            r_sum  <= n_sum;
        end
    end

    // hand the beat to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok.valid <= n_tok.valid;
        end
        r_tok.done  <= n_tok.done;
        r_tok.count <= n_tok.count;
        r_tok.req   <= n_tok.req;
        r_tok.rsp   <= n_tok.rsp;
    end

    assign o_tok = r_tok;

endmodule

### src/pibb_checker.sv
module pibb_checker import pibb_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_valid,
    input t_rsp o_rsp
);

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start && !o_busy |=> o_busy) else $error("busy not raised");

    // a result only comes while busy
    a_valid_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_busy) else $error("result while idle");

    // busy drops right after the result
    a_valid_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy) else $error("busy held after result");

    // a failed load or read never reports a match
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_rsp.status == ST_FULL || o_rsp.status == ST_RANGE)
        |-> !o_rsp.matched) else $error("match with error status");

endmodule

bind point_in_box_binning pibb_checker u_pibb_checker (
    .i_clk  (i_clk),
    .i_rst_n(i_rst_n),
    .i_start(i_start),
    .o_busy (o_busy),
    .o_valid(o_valid),
    .o_rsp  (o_rsp)
);

### dv/point_in_box_binning_tb.sv
module point_in_box_binning_tb;
    import pibb_pkg::*;

    localparam int unsigned NBOX = 256;
    localparam int unsigned LAT  = NBOX + 2;

    logic i_clk;
    logic i_rst_n;
    logic i_start;
    t_req i_req;
    logic o_busy;
    logic o_valid;
    t_rsp o_rsp;

    point_in_box_binning #(.MAX_BOXES(NBOX)) u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_req   (i_req),
        .o_busy  (o_busy),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // shadow copy of the box table
    logic signed [31:0] bx_lo_x [NBOX];
    logic signed [31:0] bx_hi_x [NBOX];
    logic signed [31:0] bx_lo_y [NBOX];
    logic signed [31:0] bx_hi_y [NBOX];
    logic [31:0]        bx_tag  [NBOX];
    logic [23:0]        bx_hits [NBOX];
    logic [55:0]        bx_sum  [NBOX];
    int unsigned        n_boxes;

    t_rsp totals_due [$];
    int   n_mismatch;
    int   n_sent;

    // work out the response of one request and update the shadow table
    function automatic t_rsp bin_predict(t_req r);
        t_rsp        p;
        logic [31:0] tag;
        logic [56:0] s;
        tag = {r.lyr_num, r.lyr_dtype};
        p = '0;
        p.status = ST_OK;
        case (r.req_type)
            REQ_LOAD: begin
                if (n_boxes >= NBOX) begin
                    p.status = ST_FULL;
                end else begin
                    bx_lo_x[n_boxes] = r.min_x;
                    bx_hi_x[n_boxes] = r.max_x;
                    bx_lo_y[n_boxes] = r.min_y;
                    bx_hi_y[n_boxes] = r.max_y;
                    bx_tag[n_boxes]  = tag;
                    bx_hits[n_boxes] = '0;
                    bx_sum[n_boxes]  = '0;
                    p.box_index = n_boxes[7:0];
                    n_boxes++;
                end
            end
            REQ_BIN: begin
                for (int i = 0; i < n_boxes; i++) begin
                    if (bx_tag[i] == tag && r.min_x >= bx_lo_x[i] && r.min_x <= bx_hi_x[i]
                        && r.min_y >= bx_lo_y[i] && r.min_y <= bx_hi_y[i]) begin
                        if (bx_hits[i] != HITS_MAX) bx_hits[i]++;
                        s = {1'b0, bx_sum[i]} + {9'd0, r.point_value};
                        bx_sum[i] = s[56] ? SUM_MAX : s[55:0];
                        p.matched   = 1'b1;
                        p.box_index = i[7:0];
                        p.hit_count = bx_hits[i];
                        p.value_sum = bx_sum[i];
                        break;
                    end
                end
            end
            REQ_READ: begin
                p.box_index = r.read_index;
                if (r.read_index < n_boxes) begin
                    p.matched   = 1'b1;
                    p.hit_count = bx_hits[r.read_index];
                    p.value_sum = bx_sum[r.read_index];
                end else begin
                    p.status = ST_RANGE;
                end
            end
            default: n_boxes = 0;
        endcase
        return p;
    endfunction

    // result checker
    always @(posedge i_clk) begin
        t_rsp e;
        if (i_rst_n && o_valid) begin
            if (totals_due.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= 10) $display("unexpected result %h", o_rsp);
            end else begin
                e = totals_due.pop_front();
                if (o_rsp !== e) begin
                    n_mismatch++;
                    if (n_mismatch <= 10)
                        $display({"mismatch: exp m=%0d i=%0d h=%0d s=%0d st=%0d, ",
                                  "got m=%0d i=%0d h=%0d s=%0d st=%0d"},
                                 e.matched, e.box_index, e.hit_count, e.value_sum,
                                 e.status, o_rsp.matched, o_rsp.box_index,
                                 o_rsp.hit_count, o_rsp.value_sum, o_rsp.status);
                end
            end
        end
    end

    // send one beat, holding start until accepted
    task automatic send_req(t_req r);
        @(negedge i_clk);
        i_req   <= r;
        i_start <= 1'b1;
        @(posedge i_clk);
        while (o_busy) @(posedge i_clk);
        totals_due = {totals_due, bin_predict(r)};
        n_sent++;
        @(negedge i_clk);
        i_start <= 1'b0;
    endtask

    // gap of random length between bursts
    task automatic sender_gap();
        if ($urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
    endtask

    function automatic t_req mk(logic [1:0] t, logic [15:0] ln, logic [15:0] dt,
                                int x0, int y0, int x1, int y1,
                                logic [47:0] v, logic [7:0] ix);
        t_req r;
        r.req_type = t; r.lyr_num = ln; r.lyr_dtype = dt;
        r.min_x = x0; r.min_y = y0; r.max_x = x1; r.max_y = y1;
        r.point_value = v; r.read_index = ix;
        return r;
    endfunction

    function automatic t_req rand_req();
        logic [223:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        return raw[$bits(t_req)-1:0];
    endfunction

    task automatic drain();
        while (totals_due.size() != 0) @(negedge i_clk);
    endtask

    // extremes, every request type, empty box, out of range read, saturation
    task automatic test_directed();
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0));
        send_req(mk(REQ_BIN, 1, 2, 0, 0, 0, 0, 48'd5, 0));
        send_req(mk(REQ_LOAD, 16'hFFFF, 16'hFFFF, 32'h80000000, 32'h80000000,
                    32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0));
        send_req(mk(REQ_LOAD, 1, 2, 10, 10, 5, 20, 0, 0));
        send_req(mk(REQ_LOAD, 1, 2, -5, -5, 5, 5, 0, 0));
        send_req(mk(REQ_BIN, 1, 2, 7, 15, 0, 0, 48'd3, 0));
        send_req(mk(REQ_BIN, 1, 2, -5, 5, 0, 0, {48{1'b1}}, 0));
        send_req(mk(REQ_BIN, 1, 2, 5, -5, 0, 0, {48{1'b1}}, 0));
        send_req(mk(REQ_BIN, 1, 3, 0, 0, 0, 0, 48'd1, 0));
        send_req(mk(REQ_BIN, 16'hFFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF,
                    0, 0, 48'd9, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd2));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd3));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255));
        // sum saturation on box 2
        repeat (300) send_req(mk(REQ_BIN, 1, 2, 0, 0, 0, 0, {48{1'b1}}, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd2));
        send_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd0));
    endtask

    // fill the table past full, bin a point into the top entry, read it, then clear
    task automatic test_full_table();
        for (int i = 0; i < NBOX + 2; i++)
            send_req(mk(REQ_LOAD, 16'd7, 16'd7, i, i, i + 1, i + 1, 0, 0));
        send_req(mk(REQ_BIN, 7, 7, NBOX - 1, NBOX, 0, 0, 48'd1, 0));
        send_req(mk(REQ_READ, 0, 0, 0, 0, 0, 0, 0, 8'd255));
        send_req(mk(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
        drain();
    endtask

    // mostly small boxes on a few layers with points that land in them
    task automatic test_random();
        t_req r;
        int   k;
        for (int n = 0; n < 620; n++) begin
            k = $urandom_range(0, 99);
            r = rand_req();
            if (k < 90) begin
                r.lyr_num   = $urandom_range(0, 2) == 0 ? r.lyr_num
                                                        : 16'($urandom_range(0, 1));
                r.lyr_dtype = $urandom_range(0, 2) == 0 ? r.lyr_dtype
                                                        : 16'($urandom_range(0, 1));
                if (k < 25) begin
                    r.req_type = REQ_LOAD;
                    r.min_x = $signed($urandom_range(0, 60)) - 30;
                    r.min_y = $signed($urandom_range(0, 60)) - 30;
                    r.max_x = r.min_x + $signed($urandom_range(0, 30)) - 3;
                    r.max_y = r.min_y + $signed($urandom_range(0, 30)) - 3;
                end else if (k < 75) begin
                    r.req_type = REQ_BIN;
                    r.min_x = $signed($urandom_range(0, 80)) - 40;
                    r.min_y = $signed($urandom_range(0, 80)) - 40;
                    if ($urandom_range(0, 3) != 0) r.point_value = 48'($urandom_range(0, 1000));
                end else begin
                    r.req_type = REQ_READ;
                    if ($urandom_range(0, 3) != 0) r.read_index = 8'($urandom_range(0, 40));
                end
            end
            if (r.req_type == REQ_CLEAR && $urandom_range(0, 3) != 0) r.req_type = REQ_BIN;
            send_req(r);
            sender_gap();
            if (n == 300) drain();
        end
    endtask

    initial begin
        i_start    = 1'b0;
        i_req      = '0;
        i_rst_n    = 1'b0;
        n_boxes    = 0;
        n_mismatch = 0;
        n_sent     = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        test_directed();
        test_full_table();
        test_random();
        drain();
        repeat (LAT + 10) @(posedge i_clk);
        if (n_mismatch == 0 && totals_due.size() == 0) begin
            $display("point_in_box_binning_tb: done, clean");
        end else begin
            $display("point_in_box_binning_tb: done, errors");
        end
        $finish;
    end

    // timeout
    initial begin
        #20000000;
        $display("point_in_box_binning_tb: done, errors");
        $finish;
    end

endmodule
